@@ rtl/core/ittf_pkg.sv @@
// Shared types and constants of the integer-to-text formatter.
// Holds the transfer payload structs and the controller/datapath interface.
// No dependencies.
package ittf_pkg;

  // Default text capacity in characters
  localparam int unsigned MAX_CHARS_DEF = 64;

  // Width of character counts; 64-bit value gives at most 64 digits plus sign
  localparam int unsigned CNT_W = 7;

  // Quotient bits retired per division cycle
  localparam int unsigned SLICE_BITS = 8;

  // Input transfer: one number with its format
  typedef struct packed {
    logic signed [63:0] value;
    logic               wide_mode;
    logic [4:0]         radix;
    logic               signed_flag;
    logic               upper_flag;
    logic [6:0]         min_chars;
    logic [7:0]         pad_byte;
  } in_t;

  // Result transfer: one character
  typedef struct packed {
    logic [7:0] text_byte;
    logic       last_flag;
    logic       overflow_flag;
  } out_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic load;       // latch new item
    logic pow2_step;  // emit one bit-group digit
    logic div_step;   // one division slice
    logic div_first;  // first slice of a digit, clear remainder
    logic div_last;   // last slice of a digit, store it
    logic emit;       // present next text character
    logic emit_ovf;   // present the overflow result
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic pow2;       // base is a power of two
    logic shift_zero; // bit-group path has no more digits
    logic quot_zero;  // quotient after this slice is zero
    logic overflow;   // text does not fit
    logic emit_last;  // this emit is the final character
  } sts_t;

endpackage

@@ rtl/core/ittf_ctrl.sv @@
// Sequencing state machine of the integer-to-text formatter.
// Depends on ittf_pkg for the command and status structs.
module ittf_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  input  ittf_pkg::sts_t sts_i,
  output ittf_pkg::cmd_t cmd_o,
  output logic          busy
);

  typedef enum logic [1:0] {
    IDLE,
    CONV,
    LAYOUT,
    EMIT
  } state_e;

  localparam int unsigned SLC_W = $clog2(64 / ittf_pkg::SLICE_BITS);
  localparam logic [SLC_W-1:0] SLC_LAST = SLC_W'(64 / ittf_pkg::SLICE_BITS - 1);

  state_e           state_q;
  logic [SLC_W-1:0] slice_q;

  assign busy = (state_q != IDLE);

  // Command decode
  always_comb begin
    cmd_o = '0;
    unique case (state_q)
      IDLE: begin
        cmd_o.load = start;
      end
      CONV: begin
        if (sts_i.pow2) begin
          cmd_o.pow2_step = 1'b1;
        end else begin
          cmd_o.div_step  = 1'b1;
          cmd_o.div_first = (slice_q == '0);
          cmd_o.div_last  = (slice_q == SLC_LAST);
        end
      end
      LAYOUT: begin
        cmd_o.emit_ovf = sts_i.overflow;
      end
      EMIT: begin
        cmd_o.emit = 1'b1;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

  // State and slice counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= IDLE;
      slice_q <= '0;
    end else begin
      unique case (state_q)
        IDLE: begin
          slice_q <= '0;
          if (start) begin
            state_q <= CONV;
          end
        end
        CONV: begin
          if (sts_i.pow2) begin
            if (sts_i.shift_zero) begin
              state_q <= LAYOUT;
            end
          end else begin
            slice_q <= slice_q + 1'b1;
            if ((slice_q == SLC_LAST) && sts_i.quot_zero) begin
              state_q <= LAYOUT;
            end
          end
        end
        LAYOUT: begin
          state_q <= sts_i.overflow ? IDLE : EMIT;
        end
        EMIT: begin
          if (sts_i.emit_last) begin
            state_q <= IDLE;
          end
        end
        default: begin
          state_q <= IDLE;
        end
      endcase
    end
  end

endmodule

@@ rtl/core/ittf_dp.sv @@
// Datapath of the integer-to-text formatter: digit generation, text store,
// character layout and result register. Depends on ittf_pkg.
module ittf_dp #(
  parameter int unsigned MAX_CHARS = ittf_pkg::MAX_CHARS_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  ittf_pkg::in_t  item_i,
  input  ittf_pkg::cmd_t cmd_i,
  output ittf_pkg::sts_t sts_o,
  output logic           res_valid_o,
  output ittf_pkg::out_t res_o
);

  localparam int unsigned ADDR_W = $clog2(MAX_CHARS);
  localparam int unsigned CNT_W  = ittf_pkg::CNT_W;
  localparam int unsigned SB     = ittf_pkg::SLICE_BITS;
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_CHARS);

  typedef enum logic [1:0] {
    SEL_PAD,
    SEL_SIGN,
    SEL_DIGIT
  } sel_e;

  // Digit value to ASCII
  function automatic logic [7:0] hex_char(input logic [3:0] d, input logic up);
    logic [7:0] c;
    if (d < 4'd10) begin
      c = 8'h30 + {4'h0, d};
    end else begin
      c = (up ? 8'h41 : 8'h61) + {4'h0, d} - 8'd10;
    end
    return c;
  endfunction

  // Work registers
  logic [63:0]      w_q;
  logic [3:0]       rem_q;
  logic [CNT_W-1:0] ndig_q;
  logic [CNT_W-1:0] pos_q;
  logic [4:0]       radix_q;
  logic [2:0]       shift_q;
  logic             pow2_q;
  logic             neg_q;
  logic             upper_q;
  logic [CNT_W-1:0] minc_q;
  logic [7:0]       pad_q;

  // Text store and result stage
  logic [7:0]       mem [MAX_CHARS];
  logic [7:0]       rd_q;
  sel_e             sel_q;
  logic             vld_q;
  logic             last_q;
  logic             ovf_q;

  // Load decode
  logic [4:0]  ld_radix;
  logic [63:0] ld_mask;
  logic [63:0] ld_neg;
  logic        ld_raw;
  logic        ld_pow2;
  logic        ld_sign;
  logic [2:0]  ld_shift;

  always_comb begin
    if (item_i.radix < 5'd2) begin
      ld_radix = 5'd2;
    end else if (item_i.radix > 5'd16) begin
      ld_radix = 5'd16;
    end else begin
      ld_radix = item_i.radix;
    end
    ld_mask  = item_i.wide_mode ? item_i.value : {32'h0, item_i.value[31:0]};
    ld_neg   = 64'd0 - ld_mask;
    if (!item_i.wide_mode) begin
      ld_neg = {32'h0, ld_neg[31:0]};
    end
    ld_raw   = (ld_radix == 5'd8) || (ld_radix == 5'd16);
    ld_pow2  = ld_raw || (ld_radix == 5'd2) || (ld_radix == 5'd4);
    ld_sign  = item_i.signed_flag && !ld_raw &&
               (item_i.wide_mode ? item_i.value[63] : item_i.value[31]);
    unique case (ld_radix)
      5'd2:    ld_shift = 3'd1;
      5'd4:    ld_shift = 3'd2;
      5'd8:    ld_shift = 3'd3;
      default: ld_shift = 3'd4;
    endcase
  end

  // Bit-group digit
  logic [3:0]  grp_mask;
  logic [3:0]  grp_digit;
  logic [63:0] grp_next;

  assign grp_mask  = 4'((5'd1 << shift_q) - 5'd1);
  assign grp_digit = w_q[3:0] & grp_mask;
  assign grp_next  = w_q >> shift_q;

  // One division slice: SB restoring steps on a narrow remainder
  logic [3:0]    div_rem;
  logic [SB-1:0] div_q;
  logic [63:0]   quot_next;

  always_comb begin
    logic [4:0] t;
    div_rem = cmd_i.div_first ? 4'd0 : rem_q;
    div_q   = '0;
    for (int i = 0; i < SB; i++) begin
      t = {div_rem, w_q[63-i]};
      if (t >= radix_q) begin
        t = t - radix_q;
        div_q[SB-1-i] = 1'b1;
      end
      div_rem = t[3:0];
    end
    quot_next = {w_q[63-SB:0], div_q};
  end

  // Layout of the finished text
  logic [CNT_W-1:0]  total;
  logic [CNT_W-1:0]  npad;
  logic [CNT_W-1:0]  out_len;
  logic [CNT_W-1:0]  rd_idx;
  logic [ADDR_W-1:0] rd_addr;
  sel_e              sel;

  assign total   = ndig_q + CNT_W'(neg_q);
  assign npad    = (minc_q > total) ? (minc_q - total) : '0;
  assign out_len = (minc_q > total) ? minc_q : total;
  assign rd_idx  = out_len - CNT_W'(1) - pos_q;
  assign rd_addr = rd_idx[ADDR_W-1:0];

  always_comb begin
    if (pos_q < npad) begin
      sel = SEL_PAD;
    end else if (neg_q && (pos_q == npad)) begin
      sel = SEL_SIGN;
    end else begin
      sel = SEL_DIGIT;
    end
  end

  assign sts_o.pow2       = pow2_q;
  assign sts_o.shift_zero = (grp_next == 64'd0);
  assign sts_o.quot_zero  = (quot_next == 64'd0);
  assign sts_o.overflow   = (total > MAX_CNT);
  assign sts_o.emit_last  = (pos_q == out_len - CNT_W'(1));

  // Digit write into the text store
  logic             wr_en;
  logic [7:0]       wr_char;

  assign wr_en   = (cmd_i.pow2_step || (cmd_i.div_step && cmd_i.div_last)) &&
                   (ndig_q < MAX_CNT);
  assign wr_char = cmd_i.pow2_step ? hex_char(grp_digit, upper_q)
                                   : hex_char(div_rem, 1'b0);

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[ndig_q[ADDR_W-1:0]] <= wr_char;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      rd_q <= mem[rd_addr];
    end
  end

  // Format payload, captured per item; output source select, captured per emit
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      radix_q <= ld_radix;
      shift_q <= ld_shift;
      upper_q <= item_i.upper_flag && ld_raw;
      minc_q  <= (item_i.min_chars > MAX_CNT) ? MAX_CNT : item_i.min_chars;
      pad_q   <= item_i.pad_byte;
    end
    if (cmd_i.emit) begin
      sel_q <= sel;
    end
  end

  // Conversion state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_q    <= '0;
      rem_q  <= '0;
      ndig_q <= '0;
      pos_q  <= '0;
      pow2_q <= 1'b0;
      neg_q  <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        w_q    <= ld_sign ? ld_neg : ld_mask;
        ndig_q <= '0;
        pos_q  <= '0;
        pow2_q <= ld_pow2;
        neg_q  <= ld_sign;
      end
      if (cmd_i.pow2_step) begin
        w_q    <= grp_next;
        ndig_q <= ndig_q + 1'b1;
      end
      if (cmd_i.div_step) begin
        w_q   <= quot_next;
        rem_q <= div_rem;
        if (cmd_i.div_last) begin
          ndig_q <= ndig_q + 1'b1;
        end
      end
      if (cmd_i.emit) begin
        pos_q <= pos_q + 1'b1;
      end
    end
  end

  // Result strobe stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= 1'b0;
      last_q <= 1'b0;
      ovf_q  <= 1'b0;
    end else begin
      vld_q  <= cmd_i.emit || cmd_i.emit_ovf;
      last_q <= cmd_i.emit_ovf || (cmd_i.emit && sts_o.emit_last);
      ovf_q  <= cmd_i.emit_ovf;
    end
  end

  always_comb begin
    res_o.last_flag     = last_q;
    res_o.overflow_flag = ovf_q;
    if (ovf_q) begin
      res_o.text_byte = 8'h00;
    end else begin
      unique case (sel_q)
        SEL_PAD:   res_o.text_byte = pad_q;
        SEL_SIGN:  res_o.text_byte = 8'h2d;
        SEL_DIGIT: res_o.text_byte = rd_q;
        default:   res_o.text_byte = rd_q;
      endcase
    end
  end

  assign res_valid_o = vld_q;

endmodule

@@ rtl/core/integer_to_text_formatter_unit.sv @@
// Top level of the integer-to-text formatter.
// Instantiates ittf_ctrl and ittf_dp; depends on ittf_pkg.
//
// Usage:
//   Drive item_i and raise start; the number is taken at a clock edge with
//   start high and busy low. busy then stays high until the text is issued.
//   Characters come out most significant first on res_o, one per cycle,
//   each marked by a single-cycle res_valid_o; last_flag marks the final
//   one. A text longer than MAX_CHARS gives one result with overflow_flag.
//   The receiver cannot stall: each strobe is a completed transfer.
// Sequence per item:
//   bases 2, 4, 8, 16: one bit group per cycle, each a digit;
//   other bases: the divider retires 8 quotient bits per cycle, and
//   each digit takes a full 64-bit pass.
//   Then a layout state, then the emit state presents the characters;
//   on overflow the emit state is skipped. busy drops after the last emit
//   cycle, and each character appears in the cycle after its emit cycle
//   (text store read is registered).
// Reset: asynchronous, active low; returns to idle with no strobe pending.
module integer_to_text_formatter_unit #(
  parameter int unsigned MAX_CHARS = ittf_pkg::MAX_CHARS_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  input  ittf_pkg::in_t  item_i,
  output logic           busy,
  output logic           res_valid_o,
  output ittf_pkg::out_t res_o
);

  ittf_pkg::cmd_t cmd;
  ittf_pkg::sts_t sts;

  // Sequencer
  ittf_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .sts_i  (sts),
    .cmd_o  (cmd),
    .busy   (busy)
  );

  // Conversion datapath and text store
  ittf_dp #(
    .MAX_CHARS (MAX_CHARS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_i      (item_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .res_valid_o (res_valid_o),
    .res_o       (res_o)
  );

`ifndef SYNTHESIS
  // An accepted item keeps the block busy
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("block not busy after accepting an item");

  // Every result belongs to work that was in flight
  a_res_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> $past(busy))
    else $error("result strobe without work in flight");

  // The final character closes the item
  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_o.last_flag) |-> !busy)
    else $error("busy still high on the final character");

  // Overflow is always a single, final result
  a_ovf_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_o.overflow_flag) |-> (res_o.last_flag && !$past(res_valid_o)))
    else $error("overflow result not a lone final transfer");
`endif

endmodule
